### hdl/lfg_pkg.sv
package lfg_pkg;

  localparam int LFG_MAX_REGION  = 65536;
  localparam int LFG_LEN_W       = 17;
  localparam int LFG_LEN_MAX     = (1 << LFG_LEN_W) - 1;
  localparam int LFG_SAMPLE_W    = 16;
  localparam int LFG_NARROW_W    = 8;
  localparam int LFG_GAIN_SHIFT  = 10;
  localparam int LFG_QUOT_W      = LFG_GAIN_SHIFT + 1;
  localparam int LFG_DIVIDEND_W  = LFG_LEN_W + LFG_GAIN_SHIFT;
  localparam int LFG_PROD_W      = LFG_QUOT_W + 1 + LFG_SAMPLE_W;
  localparam int LFG_QUEUE_DEPTH = 2;
  localparam int LFG_CFG_INDEX_W = 2;
  localparam int LFG_CFG_DATA_W  = LFG_LEN_W;

  localparam logic [LFG_CFG_INDEX_W-1:0] REG_FADE_IN       = 2'd0;
  localparam logic [LFG_CFG_INDEX_W-1:0] REG_WIDE_SAMPLES  = 2'd1;
  localparam logic [LFG_CFG_INDEX_W-1:0] REG_REGION_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_FIN
  } lfg_state_t;

  // one classified item, handed from front to back
  typedef struct packed {
    logic [LFG_DIVIDEND_W-1:0] dividend;
    logic [LFG_LEN_W-1:0]      divisor;
    logic                      neg;
    logic                      wide;
    logic [LFG_SAMPLE_W-1:0]   sample;
    logic                      last;
  } lfg_cmd_t;

endpackage

### hdl/lfg_if.sv
interface lfg_sample_if import lfg_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [LFG_SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface lfg_result_if import lfg_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [LFG_SAMPLE_W-1:0] sample_out;
  logic                           region_end;

  modport source (output valid, output sample_out, output region_end, input ready);
  modport sink (input valid, input sample_out, input region_end, output ready);
endinterface

interface lfg_cfg_if import lfg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [LFG_CFG_INDEX_W-1:0] index;
  logic [LFG_CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/lfg_front.sv
module lfg_front import lfg_pkg::*; #(
  parameter int MAX_REGION = LFG_MAX_REGION
) (
  input  logic         clk,
  input  logic         rst,
  lfg_cfg_if.sink      cfg,
  lfg_sample_if.sink   samples,
  input  logic         queue_full,
  output logic         push,
  output lfg_cmd_t     push_cmd
);

  localparam int EffMax = (MAX_REGION < LFG_LEN_MAX) ? MAX_REGION : LFG_LEN_MAX;
  localparam int PosW   = $clog2(EffMax);

  logic                   fade_in;
  logic                   wide_samples;
  logic [LFG_LEN_W-1:0]   region_length;
  logic [PosW-1:0]        position;

  logic [LFG_LEN_W-1:0]   len;
  logic [LFG_LEN_W-1:0]   pos_ext;
  logic [LFG_LEN_W-1:0]   idx;
  logic [LFG_LEN_W-1:0]   k;
  logic                   last;
  logic                   neg8;
  logic [LFG_NARROW_W-1:0] mag8;
  logic [LFG_LEN_W+LFG_NARROW_W-1:0] narrow_prod;

  assign cfg.ready     = 1'b1;
  assign samples.ready = !queue_full;
  assign push          = samples.valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in       <= 1'b1;
      wide_samples  <= 1'b1;
      region_length <= LFG_LEN_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FADE_IN:       fade_in       <= cfg.data[0];
        REG_WIDE_SAMPLES:  wide_samples  <= cfg.data[0];
        REG_REGION_LENGTH: region_length <= cfg.data[LFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (region_length == '0) begin
      len = LFG_LEN_W'(1);
    end else if (int'(region_length) > MAX_REGION) begin
      len = LFG_LEN_W'(MAX_REGION);
    end else begin
      len = region_length;
    end
    pos_ext = LFG_LEN_W'(position);
    // a length lowered mid-region pins the index to the last sample
    if (pos_ext >= len - LFG_LEN_W'(1)) begin
      idx  = len - LFG_LEN_W'(1);
      last = 1'b1;
    end else begin
      idx  = pos_ext;
      last = 1'b0;
    end
    k = fade_in ? idx : (len - idx);

    neg8 = samples.sample_in[LFG_NARROW_W-1];
    mag8 = neg8 ? LFG_NARROW_W'(~samples.sample_in[LFG_NARROW_W-1:0] + 1'b1)
                : samples.sample_in[LFG_NARROW_W-1:0];
    narrow_prod = {{LFG_NARROW_W{1'b0}}, k} * {{LFG_LEN_W{1'b0}}, mag8};

    push_cmd.divisor = len;
    push_cmd.wide    = wide_samples;
    push_cmd.sample  = samples.sample_in;
    push_cmd.last    = last;
    if (wide_samples) begin
      push_cmd.dividend = {k, {LFG_GAIN_SHIFT{1'b0}}};
      push_cmd.neg      = 1'b0;
    end else begin
      push_cmd.dividend = LFG_DIVIDEND_W'(narrow_prod);
      push_cmd.neg      = neg8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (push) begin
      position <= last ? '0 : PosW'(idx + LFG_LEN_W'(1));
    end
  end

endmodule

### hdl/lfg_queue.sv
module lfg_queue import lfg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lfg_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output lfg_cmd_t head
);

  localparam int PtrW = (LFG_QUEUE_DEPTH > 1) ? $clog2(LFG_QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(LFG_QUEUE_DEPTH + 1);

  lfg_cmd_t        entries [LFG_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(LFG_QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(LFG_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(LFG_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/lfg_back.sv
module lfg_back import lfg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  lfg_cmd_t   head,
  output logic       pop,
  lfg_result_if.source faded
);

  localparam int CntW = $clog2(LFG_QUOT_W);

  lfg_state_t state;
  lfg_state_t state_next;

  logic [LFG_LEN_W-1:0]             rem;
  logic [LFG_QUOT_W-1:0]            dq;
  logic [LFG_LEN_W-1:0]             divisor;
  logic [CntW-1:0]                  cnt;
  logic                             neg;
  logic                             wide;
  logic                             last;
  logic signed [LFG_SAMPLE_W-1:0]   x;
  logic signed [LFG_PROD_W-1:0]     prod;

  logic                             out_valid;
  logic signed [LFG_SAMPLE_W-1:0]   out_sample;
  logic                             out_last;
  logic                             out_load;

  logic [LFG_LEN_W:0]               trial;
  logic [LFG_LEN_W:0]               diff;
  logic                             fits;
  logic signed [LFG_PROD_W-1:0]     biased;
  logic signed [LFG_PROD_W-1:0]     wide_y;
  logic [LFG_SAMPLE_W-1:0]          q_ext;
  logic [LFG_SAMPLE_W-1:0]          y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == CntW'(LFG_QUOT_W - 1)) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || faded.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // restoring divide, one quotient bit per cycle; partial remainder starts below divisor
  always_comb begin
    trial  = {rem, dq[LFG_QUOT_W-1]};
    diff   = trial - {1'b0, divisor};
    fits   = (trial >= {1'b0, divisor});
    biased = prod + (prod[LFG_PROD_W-1] ? LFG_PROD_W'((1 << LFG_GAIN_SHIFT) - 1)
                                        : LFG_PROD_W'(0));
    wide_y = biased >>> LFG_GAIN_SHIFT;
    q_ext  = LFG_SAMPLE_W'(dq);
    if (wide) begin
      y = wide_y[LFG_SAMPLE_W-1:0];
    end else begin
      y = neg ? LFG_SAMPLE_W'(~q_ext + 1'b1) : q_ext;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rem     <= LFG_LEN_W'(head.dividend[LFG_DIVIDEND_W-1:LFG_QUOT_W]);
        dq      <= head.dividend[LFG_QUOT_W-1:0];
        divisor <= head.divisor;
        neg     <= head.neg;
        wide    <= head.wide;
        last    <= head.last;
        x       <= head.sample;
        cnt     <= '0;
      end
      ST_DIV: begin
        rem <= fits ? diff[LFG_LEN_W-1:0] : trial[LFG_LEN_W-1:0];
        dq  <= {dq[LFG_QUOT_W-2:0], fits};
        cnt <= cnt + 1'b1;
      end
      ST_SCALE: prod <= $signed({1'b0, dq}) * x;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (faded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= y;
      out_last   <= last;
    end
  end

  assign faded.valid      = out_valid;
  assign faded.sample_out = out_sample;
  assign faded.region_end = out_last;

endmodule

### hdl/linear_fade_gain_core.sv
// linear fade envelope over a region of signed audio samples
// samples: one sample per transfer; faded: one faded sample per input, with
// region_end high on the last sample of the region; cfg: register writes
// (0 fade_in, 1 wide_samples, 2 region_length), always ready, other indexes
// ignored. write cfg only while no sample is in flight.
// the front side holds the registers and the position counter, works out the
// weight and the divide operands for each sample and drops them into a
// two-entry queue; it keeps taking samples while the queue has room.
// the back side runs one restoring divide by the region length per sample,
// one quotient bit a cycle, then scales in 16-bit mode; it pops a new sample
// only after the last one has left the shared divider and been loaded into
// the output register.
// up to four samples can be in flight (queue, divider, output register).
// reset: fade-in, 16-bit mode, region length 1, position 0, queue empty.
// when faded.ready is low the output register holds; the divider finishes
// its current sample and the queue then fills before samples.ready drops.
module linear_fade_gain_core import lfg_pkg::*; #(
  parameter int MAX_REGION = LFG_MAX_REGION
) (
  input  logic          clk,
  input  logic          rst,
  lfg_cfg_if.sink       cfg,
  lfg_sample_if.sink    samples,
  lfg_result_if.source  faded
);

  logic     push;
  lfg_cmd_t push_cmd;
  logic     queue_full;
  logic     pop;
  logic     empty;
  lfg_cmd_t head;

  lfg_front #(
    .MAX_REGION (MAX_REGION)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .samples    (samples),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lfg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  lfg_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .faded (faded)
  );

endmodule

### hdl/lfg_checker.sv
module lfg_checker import lfg_pkg::*; (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [LFG_SAMPLE_W-1:0] sample_out,
  input logic                           region_end
);

  localparam int MaxInFlight = LFG_QUEUE_DEPTH + 2;
  localparam int CntW        = $clog2(MaxInFlight + 2);

  logic [CntW-1:0] in_flight;
  logic            in_xfer;
  logic            out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   in_flight <= in_flight + 1'b1;
        2'b01:   in_flight <= in_flight - 1'b1;
        default: in_flight <= in_flight;
      endcase
    end
  end

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(region_end))
    else $error("stalled result changed");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> in_flight != '0)
    else $error("result without a pending sample");

  a_in_flight_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CntW'(MaxInFlight))
    else $error("more samples in flight than storage allows");

endmodule

bind linear_fade_gain_core lfg_checker u_lfg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (faded.valid),
  .out_ready  (faded.ready),
  .sample_out (faded.sample_out),
  .region_end (faded.region_end)
);
